// ===== rtl/core/tli_pkg.sv =====
// Shared types, constants and the quarter-wave sine table of the turtle line interpreter.
// Depends on nothing; every other file of the block imports it.
`default_nettype none

package tli_pkg;

  localparam int STACK_DEPTH     = 64;
  localparam int SINE_TABLE_BITS = 10;

  localparam int QSTEPS  = 1 << SINE_TABLE_BITS;
  localparam int IDX_LSB = 14 - SINE_TABLE_BITS;
  localparam int TRIG_W  = 17;
  localparam int STK_AW  = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int STK_CW  = $clog2(STACK_DEPTH + 1);

  localparam logic [7:0] SYM_PLUS  = 8'h2B;
  localparam logic [7:0] SYM_MINUS = 8'h2D;
  localparam logic [7:0] SYM_OPEN  = 8'h28;
  localparam logic [7:0] SYM_CLOSE = 8'h29;

  typedef enum logic [2:0] {
    REG_START_HEADING  = 3'd0,
    REG_TURN_STEP      = 3'd1,
    REG_DRAW_MASK_LOW  = 3'd2,
    REG_DRAW_MASK_ML   = 3'd3,
    REG_DRAW_MASK_MH   = 3'd4,
    REG_DRAW_MASK_HIGH = 3'd5
  } cfg_reg_e;

  typedef enum logic [1:0] {
    ST_LINE       = 2'd0,
    ST_POP_EMPTY  = 2'd1,
    ST_PUSH_FULL  = 2'd2
  } status_e;

  typedef logic [STK_AW-1:0]          stk_addr_t;
  typedef logic [STK_CW-1:0]          stk_cnt_t;
  typedef logic [SINE_TABLE_BITS-1:0] rom_addr_t;
  // low half: q[idx], high half: q[N-idx]
  typedef logic [2*TRIG_W-1:0]        trig_pair_t;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic [15:0]        h;
  } frame_t;

  typedef struct packed {
    logic      we;
    stk_addr_t waddr;
    stk_addr_t raddr;
    frame_t    wdata;
  } stack_req_t;

  typedef struct packed {
    logic signed [31:0] from_x;
    logic signed [31:0] from_y;
    logic signed [31:0] to_x;
    logic signed [31:0] to_y;
    status_e            status;
  } result_t;

  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
  localparam longint unsigned TAYLOR_DIV [7] = '{6, 20, 42, 72, 110, 156, 210};

  // sin(pi/2 * k/N) in unsigned Q1.16 via a Q30 Taylor series, evaluated at elaboration
  function automatic logic [TRIG_W-1:0] quarter_sine(input int unsigned k);
    longint unsigned theta;
    longint unsigned term;
    longint unsigned r;
    longint          sum;
    theta = (HALF_PI_Q30 * longint'(k)) >> SINE_TABLE_BITS;
    term  = theta;
    sum   = longint'(theta);
    for (int n = 0; n < 7; n++) begin
      term = (term * theta) >> 30;
      term = (term * theta) >> 30;
      term = term / TAYLOR_DIV[n];
      if ((n & 1) == 0) begin
        sum = sum - longint'(term);
      end else begin
        sum = sum + longint'(term);
      end
    end
    if (sum < 0) begin
      sum = 0;
    end
    r = (longint'(sum) + 64'd8192) >> 14;
    if (r > 64'd65536) begin
      r = 64'd65536;
    end
    return r[TRIG_W-1:0];
  endfunction

  typedef trig_pair_t sine_rom_t [QSTEPS];

  function automatic sine_rom_t build_sine_rom();
    sine_rom_t rom;
    for (int k = 0; k < QSTEPS; k++) begin
      rom[k] = {quarter_sine(QSTEPS - k), quarter_sine(k)};
    end
    return rom;
  endfunction

  localparam sine_rom_t SINE_ROM = build_sine_rom();

endpackage

`default_nettype wire

// ===== rtl/core/tli_sine_rom.sv =====
// Dual-port quarter-wave sine ROM with registered read data.
// Depends on tli_pkg (SINE_ROM contents).
`default_nettype none

module tli_sine_rom
  import tli_pkg::*;
(
  input  wire logic       clk,
  input  wire rom_addr_t  addr_a,
  input  wire rom_addr_t  addr_b,
  output      trig_pair_t data_a,
  output      trig_pair_t data_b
);

  trig_pair_t data_a_r;
  trig_pair_t data_b_r;

  always_ff @(posedge clk) begin
    data_a_r <= SINE_ROM[addr_a];
    data_b_r <= SINE_ROM[addr_b];
  end

  assign data_a = data_a_r;
  assign data_b = data_b_r;

endmodule

`default_nettype wire

// ===== rtl/core/tli_stack_mem.sv =====
// Branch stack memory: one write port, one registered read port tracking top of stack.
// Forwards a write that lands on the entry being read in the same cycle. Depends on tli_pkg.
`default_nettype none

module tli_stack_mem
  import tli_pkg::*;
(
  input  wire logic       clk,
  input  wire stack_req_t req,
  output      frame_t     top
);

  frame_t mem [STACK_DEPTH];
  frame_t rd_r;
  frame_t fwd_r;
  logic   fwd_valid_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rd_r        <= mem[req.raddr];
    fwd_r       <= req.wdata;
    fwd_valid_r <= req.we && (req.waddr == req.raddr);
  end

  assign top = fwd_valid_r ? fwd_r : rd_r;

endmodule

`default_nettype wire

// ===== rtl/core/tli_out_buf.sv =====
// Two-entry output buffer (output register plus skid) for result transfers.
// Ready towards the core is registered. Depends on tli_pkg.
`default_nettype none

module tli_out_buf
  import tli_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    push_valid,
  input  wire result_t push_data,
  output      logic    push_ready,
  output      logic    out_valid,
  output      result_t out_data,
  input  wire logic    out_ready
);

  logic    main_valid_r;
  logic    skid_valid_r;
  result_t main_r;
  result_t skid_r;
  logic    pop;

  assign pop        = main_valid_r && out_ready;
  assign push_ready = !skid_valid_r;
  assign out_valid  = main_valid_r;
  assign out_data   = main_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (pop && skid_valid_r) begin
      main_r       <= skid_r;
      skid_valid_r <= 1'b0;
    end else if (pop || !main_valid_r) begin
      main_valid_r <= push_valid;
      main_r       <= push_data;
    end else if (push_valid) begin
      skid_r       <= push_data;
      skid_valid_r <= 1'b1;
    end
  end

`ifndef SYNTH
  a_skid_behind_main: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> main_valid_r)
    else $error("skid entry held while output register empty");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/turtle_line_interpreter_unit.sv =====
// Top level of the turtle line interpreter: config registers, turtle state and step logic.
// Uses tli_sine_rom, tli_stack_mem and tli_out_buf; depends on tli_pkg.
//
//   channel | dir | handshake          | payload
//   in_     | in  | in_tvalid/tready   | tdata: symbol; tuser: restart
//   out_    | out | out_tvalid/tready  | tdata: from_x,from_y,to_x,to_y; tuser: status
//   cfg_    | in  | cfg_valid/ready    | cfg_index, cfg_data (cfg_ready always high)
//
// One symbol per cycle while in_tready is high; a result is written into the output
// buffer on its input transfer and leaves through the output register. The step is bounded
// by the heading feeding the sine ROM port and the stack read address for the next symbol.
// Reset clears position, heading, stack count and registers; stack entries stay
// undefined until written and need no clearing pass.
// in_tready drops during reset and while both output buffer entries are held by a
// stalled sink.
`default_nettype none

module turtle_line_interpreter_unit
  import tli_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output      logic         in_tready,
  input  wire logic [7:0]   in_tdata,   // [7:0] symbol
  input  wire logic [0:0]   in_tuser,   // [0] restart
  output      logic         out_tvalid,
  input  wire logic         out_tready,
  output      logic [127:0] out_tdata,  // [31:0] from_x, [63:32] from_y, [95:64] to_x,
                                        // [127:96] to_y
  output      logic [1:0]   out_tuser,  // [1:0] status
  input  wire logic         cfg_valid,
  output      logic         cfg_ready,
  input  wire logic [2:0]   cfg_index,
  input  wire logic [63:0]  cfg_data
);

  logic [15:0]  start_heading_r;
  logic [15:0]  turn_step_r;
  logic [255:0] draw_mask_r;

  logic signed [31:0] pos_x_r, pos_x_nxt;
  logic signed [31:0] pos_y_r, pos_y_nxt;
  logic [15:0]        heading_r, heading_nxt;
  stk_cnt_t           count_r, count_nxt;

  logic       in_acc;
  logic [7:0] sym;
  logic       restart;

  trig_pair_t rom_a, rom_b;
  rom_addr_t  rom_addr_a, rom_addr_b;
  frame_t     top;
  stack_req_t stk_req;

  logic signed [31:0] b_x, b_y, b_sin, b_cos, adv_x, adv_y;
  logic [15:0]        b_h;
  stk_cnt_t           b_cnt, cnt_m1;
  logic signed [31:0] s_x, s_y;
  logic [15:0]        s_h;
  stk_cnt_t           s_cnt;
  logic               s_we, s_res;
  result_t            res;
  logic               res_ready;

  function automatic logic signed [31:0] trig_val(input trig_pair_t p, input logic odd,
                                                  input logic neg);
    logic [TRIG_W-1:0]  mag;
    logic signed [31:0] v;
    mag = odd ? p[2*TRIG_W-1:TRIG_W] : p[TRIG_W-1:0];
    v   = {{(32-TRIG_W){1'b0}}, mag};
    return neg ? -v : v;
  endfunction

  function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
    logic signed [32:0] s;
    s = {a[31], a} + {b[31], b};
    if (s[32] != s[31]) begin
      return s[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end
    return s[31:0];
  endfunction

  // ---------------- configuration ----------------
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_heading_r <= '0;
      turn_step_r     <= '0;
      draw_mask_r     <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_reg_e'(cfg_index))
        REG_START_HEADING:  start_heading_r     <= cfg_data[15:0];
        REG_TURN_STEP:      turn_step_r         <= cfg_data[15:0];
        REG_DRAW_MASK_LOW:  draw_mask_r[63:0]    <= cfg_data;
        REG_DRAW_MASK_ML:   draw_mask_r[127:64]  <= cfg_data;
        REG_DRAW_MASK_MH:   draw_mask_r[191:128] <= cfg_data;
        REG_DRAW_MASK_HIGH: draw_mask_r[255:192] <= cfg_data;
        default: ;
      endcase
    end
  end

  // ---------------- step logic ----------------
  assign in_acc  = in_tvalid && in_tready;
  assign sym     = in_tdata;
  assign restart = in_tuser[0];

  // ROM port A follows the heading, port B the start heading (restart case)
  always_comb begin
    if (restart) begin
      b_x   = '0;
      b_y   = '0;
      b_h   = start_heading_r;
      b_cnt = '0;
      b_sin = trig_val(rom_b, start_heading_r[14], start_heading_r[15]);
      b_cos = trig_val(rom_b, !start_heading_r[14], start_heading_r[15] ^ start_heading_r[14]);
    end else begin
      b_x   = pos_x_r;
      b_y   = pos_y_r;
      b_h   = heading_r;
      b_cnt = count_r;
      b_sin = trig_val(rom_a, heading_r[14], heading_r[15]);
      b_cos = trig_val(rom_a, !heading_r[14], heading_r[15] ^ heading_r[14]);
    end
    adv_x = sat_add(b_x, b_cos);
    adv_y = sat_add(b_y, b_sin);

    s_x   = b_x;
    s_y   = b_y;
    s_h   = b_h;
    s_cnt = b_cnt;
    s_we  = 1'b0;
    s_res = 1'b0;
    res.from_x = b_x;
    res.from_y = b_y;
    res.to_x   = b_x;
    res.to_y   = b_y;
    res.status = ST_LINE;

    unique case (sym)
      SYM_PLUS:  s_h = b_h + turn_step_r;
      SYM_MINUS: s_h = b_h - turn_step_r;
      SYM_OPEN: begin
        if (b_cnt == STK_CW'(STACK_DEPTH)) begin
          s_res      = 1'b1;
          res.status = ST_PUSH_FULL;
        end else begin
          s_we  = 1'b1;
          s_cnt = b_cnt + STK_CW'(1);
        end
      end
      SYM_CLOSE: begin
        if (b_cnt == '0) begin
          s_res      = 1'b1;
          res.status = ST_POP_EMPTY;
        end else begin
          s_cnt = b_cnt - STK_CW'(1);
          s_x   = top.x;
          s_y   = top.y;
          s_h   = top.h;
        end
      end
      default: begin
        s_x        = adv_x;
        s_y        = adv_y;
        res.to_x   = adv_x;
        res.to_y   = adv_y;
        s_res      = draw_mask_r[sym];
      end
    endcase

    if (in_acc) begin
      pos_x_nxt   = s_x;
      pos_y_nxt   = s_y;
      heading_nxt = s_h;
      count_nxt   = s_cnt;
    end else begin
      pos_x_nxt   = pos_x_r;
      pos_y_nxt   = pos_y_r;
      heading_nxt = heading_r;
      count_nxt   = count_r;
    end

    // keep the read port on the entry below count_nxt so the top is ready next cycle
    cnt_m1          = (count_nxt == '0) ? '0 : count_nxt - STK_CW'(1);
    stk_req.we      = in_acc && s_we;
    stk_req.waddr   = b_cnt[STK_AW-1:0];
    stk_req.raddr   = cnt_m1[STK_AW-1:0];
    stk_req.wdata.x = b_x;
    stk_req.wdata.y = b_y;
    stk_req.wdata.h = b_h;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_x_r   <= '0;
      pos_y_r   <= '0;
      heading_r <= '0;
      count_r   <= '0;
    end else begin
      pos_x_r   <= pos_x_nxt;
      pos_y_r   <= pos_y_nxt;
      heading_r <= heading_nxt;
      count_r   <= count_nxt;
    end
  end

  // ROM addresses track the values the registers take at this edge
  assign rom_addr_a = rst_n ? heading_nxt[13:IDX_LSB] : '0;
  assign rom_addr_b = !rst_n ? '0 :
                      (cfg_valid && cfg_ready &&
                       cfg_reg_e'(cfg_index) == REG_START_HEADING) ? cfg_data[13:IDX_LSB] :
                      start_heading_r[13:IDX_LSB];

  // ---------------- submodules ----------------
  tli_sine_rom u_rom (
    .clk    (clk),
    .addr_a (rom_addr_a),
    .addr_b (rom_addr_b),
    .data_a (rom_a),
    .data_b (rom_b)
  );

  tli_stack_mem u_stack (
    .clk (clk),
    .req (stk_req),
    .top (top)
  );

  result_t out_res;

  tli_out_buf u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (in_acc && s_res),
    .push_data  (res),
    .push_ready (res_ready),
    .out_valid  (out_tvalid),
    .out_data   (out_res),
    .out_ready  (out_tready)
  );

  assign in_tready = res_ready && rst_n;
  assign out_tdata = {out_res.to_y, out_res.to_x, out_res.from_y, out_res.from_x};
  assign out_tuser = out_res.status;

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= STK_CW'(STACK_DEPTH))
    else $error("stack count above depth");

  a_pop_decrements: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && !restart && sym == SYM_CLOSE && count_r != '0
    |=> count_r == $past(count_r) - STK_CW'(1))
    else $error("pop did not decrement stack count");

  a_error_holds_pos: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && s_res && res.status != ST_LINE
    |=> pos_x_r == $past(b_x) && pos_y_r == $past(b_y) && count_r == $past(b_cnt))
    else $error("stack error result changed turtle state");
`endif

endmodule

`default_nettype wire
